@@ hdl/plq_pkg.sv @@
// plq_pkg: shared types and constants for the picture list deque
// link table entries, memory access commands, opcodes, states and the result beat
// no dependencies
package plq_pkg;

    localparam int NUM_FRAMES = 16;
    localparam int FRAME_W    = 4;
    localparam int LINK_W     = 5;
    localparam int COUNT_W    = 5;
    localparam int OC_W       = 32;
    localparam int OPCODE_W   = 3;

    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(NUM_FRAMES);

    // stream payload widths, fields packed from bit 0 up, padded to whole bytes
    localparam int S_FIELDS_W = OPCODE_W + FRAME_W + OC_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 1 + FRAME_W + 1 + FRAME_W + FRAME_W + COUNT_W + 1;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_REMOVE     = 3'd4,
        OP_FIND       = 3'd5
    } plq_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH2,
        S_UNLINK_RD,
        S_UNLINK_WR2,
        S_FIND,
        S_DONE
    } plq_state_t;

    typedef struct packed {
        logic [LINK_W-1:0] next_link;
        logic [LINK_W-1:0] prev_link;
    } plq_link_t;

    typedef struct packed {
        logic               we_next;
        logic               we_prev;
        logic [FRAME_W-1:0] addr;
        plq_link_t          entry;
    } plq_link_wr_t;

    typedef struct packed {
        logic               we;
        logic [FRAME_W-1:0] addr;
        logic [OC_W-1:0]    data;
    } plq_oc_wr_t;

    typedef struct packed {
        logic               en;
        logic [FRAME_W-1:0] addr;
    } plq_rd_t;

    typedef struct packed {
        logic               is_empty;
        logic [COUNT_W-1:0] frame_count;
        logic [FRAME_W-1:0] tail_frame;
        logic [FRAME_W-1:0] head_frame;
        logic               op_error;
        logic [FRAME_W-1:0] result_frame;
        logic               hit;
    } plq_result_t;

endpackage

@@ hdl/picture_list_deque.sv @@
// picture_list_deque: ordered doubly linked list of 16 frame slots usable as a deque
// errors, empty-list pops and finds, undefined opcodes go straight to the result; push writes the
// new frame's links, then a neighbor's if the list was not empty; pop and remove read the frame's
// links, then rewrite any neighbors; find follows next links from the head; one beat in flight,
// next beat taken the cycle after its result is registered; reset: synchronous active-low aresetn
// empties the list, no clearing pass; depends on plq_pkg, plq_ctrl, plq_link_ram, plq_oc_ram
module picture_list_deque (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // opcode [2:0], frame_id [6:3], order_count [38:7], zero pad above
    input  logic [plq_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // hit [0], result_frame [4:1], op_error [5], head_frame [9:6], tail_frame [13:10],
    // frame_count [18:14], is_empty [19], zero pad above
    output logic [plq_pkg::M_TDATA_W-1:0]   m_tdata
);
    import plq_pkg::*;

    // input beat fields
    plq_op_t             in_opcode;
    logic [FRAME_W-1:0]  in_frame;
    logic [OC_W-1:0]     in_order_count;

    // sequencer to memories
    plq_rd_t             rd_req;
    plq_link_wr_t        link_wr;
    plq_oc_wr_t          oc_wr;
    plq_link_t           link_rd_data;
    logic [OC_W-1:0]     oc_rd_data;

    // result hand-off
    logic                done;
    logic                out_free;
    plq_result_t         result;

    // output register
    logic                m_valid_reg, m_valid_next;
    plq_result_t         m_res_reg, m_res_next;

    assign in_opcode      = plq_op_t'(s_tdata[OPCODE_W-1:0]);
    assign in_frame       = s_tdata[OPCODE_W +: FRAME_W];
    assign in_order_count = s_tdata[OPCODE_W+FRAME_W +: OC_W];

    plq_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_opcode      (in_opcode),
        .in_frame       (in_frame),
        .in_order_count (in_order_count),
        .out_free       (out_free),
        .done           (done),
        .result         (result),
        .rd_req         (rd_req),
        .link_rd_data   (link_rd_data),
        .oc_rd_data     (oc_rd_data),
        .link_wr        (link_wr),
        .oc_wr          (oc_wr)
    );

    plq_link_ram u_link_ram (
        .aclk    (aclk),
        .wr      (link_wr),
        .rd      (rd_req),
        .rd_data (link_rd_data)
    );

    plq_oc_ram u_oc_ram (
        .aclk    (aclk),
        .wr      (oc_wr),
        .rd      (rd_req),
        .rd_data (oc_rd_data)
    );

    // output slot is free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (done) begin
            m_valid_next = 1'b1;
            m_res_next   = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-M_FIELDS_W){1'b0}}, m_res_reg};

endmodule

@@ hdl/plq_link_ram.sv @@
// plq_link_ram: next and previous link table, one write address and one read address per cycle
// each link field has its own write enable; read data registered
// depends on plq_pkg
module plq_link_ram (
    input  logic                  aclk,
    input  plq_pkg::plq_link_wr_t wr,
    input  plq_pkg::plq_rd_t      rd,
    output plq_pkg::plq_link_t    rd_data
);
    import plq_pkg::*;

    plq_link_t mem [NUM_FRAMES];
    plq_link_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.we_next) begin
            mem[wr.addr].next_link <= wr.entry.next_link;
        end
        if (wr.we_prev) begin
            mem[wr.addr].prev_link <= wr.entry.prev_link;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/plq_oc_ram.sv @@
// plq_oc_ram: picture order count stored per frame slot
// one write and one registered read per cycle
// depends on plq_pkg
module plq_oc_ram (
    input  logic                          aclk,
    input  plq_pkg::plq_oc_wr_t           wr,
    input  plq_pkg::plq_rd_t              rd,
    output logic [plq_pkg::OC_W-1:0]      rd_data
);
    import plq_pkg::*;

    logic [OC_W-1:0] mem [NUM_FRAMES];
    logic [OC_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/plq_ctrl.sv @@
// plq_ctrl: sequencer for the list operations, holds head, tail, count and listed bits
// drives the link and order count memories and builds the result beat
// depends on plq_pkg
module plq_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  plq_pkg::plq_op_t              in_opcode,
    input  logic [plq_pkg::FRAME_W-1:0]   in_frame,
    input  logic [plq_pkg::OC_W-1:0]      in_order_count,
    input  logic                          out_free,
    output logic                          done,
    output plq_pkg::plq_result_t          result,
    output plq_pkg::plq_rd_t              rd_req,
    input  plq_pkg::plq_link_t            link_rd_data,
    input  logic [plq_pkg::OC_W-1:0]      oc_rd_data,
    output plq_pkg::plq_link_wr_t         link_wr,
    output plq_pkg::plq_oc_wr_t           oc_wr
);
    import plq_pkg::*;

    plq_state_t          state_reg, state_next;
    plq_op_t             op_reg, op_next;
    logic [FRAME_W-1:0]  frame_reg, frame_next;
    logic [OC_W-1:0]     oc_reg, oc_next;
    logic [FRAME_W-1:0]  head_reg, head_next;
    logic [FRAME_W-1:0]  tail_reg, tail_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [NUM_FRAMES-1:0] in_list_reg, in_list_next;
    logic                hit_reg, hit_next;
    logic [FRAME_W-1:0]  res_reg, res_next;
    logic                err_reg, err_next;
    logic [FRAME_W-1:0]  aux_reg, aux_next;
    logic [FRAME_W-1:0]  cur_reg, cur_next;
    plq_link_t           saved_reg, saved_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            in_list_reg <= '0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            in_list_reg <= in_list_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        frame_reg <= frame_next;
        oc_reg    <= oc_next;
        hit_reg   <= hit_next;
        res_reg   <= res_next;
        err_reg   <= err_next;
        aux_reg   <= aux_next;
        cur_reg   <= cur_next;
        saved_reg <= saved_next;
    end

    always_comb begin
        logic               list_empty;
        logic [FRAME_W-1:0] pick;
        list_empty   = (count_reg == '0);
        pick         = '0;
        state_next   = state_reg;
        op_next      = op_reg;
        frame_next   = frame_reg;
        oc_next      = oc_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        in_list_next = in_list_reg;
        hit_next     = hit_reg;
        res_next     = res_reg;
        err_next     = err_reg;
        aux_next     = aux_reg;
        cur_next     = cur_reg;
        saved_next   = saved_reg;
        rd_req       = '0;
        link_wr      = '0;
        oc_wr        = '0;
        in_ready     = 1'b0;
        done         = 1'b0;

        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next    = in_opcode;
                    frame_next = in_frame;
                    oc_next    = in_order_count;
                    hit_next   = 1'b0;
                    res_next   = '0;
                    err_next   = 1'b0;
                    state_next = S_DONE;
                    case (in_opcode)
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            if (in_list_reg[in_frame]) begin
                                err_next = 1'b1;
                            end else begin
                                oc_wr.we        = 1'b1;
                                oc_wr.addr      = in_frame;
                                oc_wr.data      = in_order_count;
                                link_wr.we_next = 1'b1;
                                link_wr.we_prev = 1'b1;
                                link_wr.addr    = in_frame;
                                if (in_opcode == OP_PUSH_FRONT) begin
                                    link_wr.entry.next_link =
                                        list_empty ? NIL_LINK : {1'b0, head_reg};
                                    link_wr.entry.prev_link = NIL_LINK;
                                    aux_next  = head_reg;
                                    head_next = in_frame;
                                    if (list_empty) begin
                                        tail_next = in_frame;
                                    end
                                end else begin
                                    link_wr.entry.prev_link =
                                        list_empty ? NIL_LINK : {1'b0, tail_reg};
                                    link_wr.entry.next_link = NIL_LINK;
                                    aux_next  = tail_reg;
                                    tail_next = in_frame;
                                    if (list_empty) begin
                                        head_next = in_frame;
                                    end
                                end
                                in_list_next[in_frame] = 1'b1;
                                count_next = count_reg + COUNT_W'(1);
                                if (!list_empty) begin
                                    state_next = S_PUSH2;
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (!list_empty) begin
                                pick        = (in_opcode == OP_POP_FRONT) ? head_reg : tail_reg;
                                hit_next    = 1'b1;
                                res_next    = pick;
                                frame_next  = pick;
                                rd_req.en   = 1'b1;
                                rd_req.addr = pick;
                                state_next  = S_UNLINK_RD;
                            end
                        end
                        OP_REMOVE: begin
                            if (!in_list_reg[in_frame]) begin
                                err_next = 1'b1;
                            end else begin
                                rd_req.en   = 1'b1;
                                rd_req.addr = in_frame;
                                state_next  = S_UNLINK_RD;
                            end
                        end
                        OP_FIND: begin
                            if (!list_empty) begin
                                rd_req.en   = 1'b1;
                                rd_req.addr = head_reg;
                                cur_next    = head_reg;
                                state_next  = S_FIND;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // second link write of a push into a non-empty list
            S_PUSH2: begin
                link_wr.addr = aux_reg;
                if (op_reg == OP_PUSH_FRONT) begin
                    link_wr.we_prev         = 1'b1;
                    link_wr.entry.prev_link = {1'b0, frame_reg};
                end else begin
                    link_wr.we_next         = 1'b1;
                    link_wr.entry.next_link = {1'b0, frame_reg};
                end
                state_next = S_DONE;
            end

            // links of the leaving frame are on the read port now
            S_UNLINK_RD: begin
                saved_next              = link_rd_data;
                count_next              = count_reg - COUNT_W'(1);
                in_list_next[frame_reg] = 1'b0;
                if (count_reg == COUNT_W'(1)) begin
                    head_next  = '0;
                    tail_next  = '0;
                    state_next = S_DONE;
                end else begin
                    if (head_reg == frame_reg) begin
                        head_next = link_rd_data.next_link[FRAME_W-1:0];
                    end
                    if (tail_reg == frame_reg) begin
                        tail_next = link_rd_data.prev_link[FRAME_W-1:0];
                    end
                    if (link_rd_data.next_link != NIL_LINK) begin
                        link_wr.we_prev         = 1'b1;
                        link_wr.addr            = link_rd_data.next_link[FRAME_W-1:0];
                        link_wr.entry.prev_link = link_rd_data.prev_link;
                    end
                    state_next = S_UNLINK_WR2;
                end
            end

            S_UNLINK_WR2: begin
                if (saved_reg.prev_link != NIL_LINK) begin
                    link_wr.we_next         = 1'b1;
                    link_wr.addr            = saved_reg.prev_link[FRAME_W-1:0];
                    link_wr.entry.next_link = saved_reg.next_link;
                end
                state_next = S_DONE;
            end

            // one list node per cycle: compare, then follow the next link
            S_FIND: begin
                if (oc_rd_data == oc_reg) begin
                    hit_next   = 1'b1;
                    res_next   = cur_reg;
                    state_next = S_DONE;
                end else if (link_rd_data.next_link == NIL_LINK) begin
                    state_next = S_DONE;
                end else begin
                    rd_req.en   = 1'b1;
                    rd_req.addr = link_rd_data.next_link[FRAME_W-1:0];
                    cur_next    = link_rd_data.next_link[FRAME_W-1:0];
                end
            end

            S_DONE: begin
                if (out_free) begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        result.hit          = hit_reg;
        result.result_frame = res_reg;
        result.op_error     = err_reg;
        result.head_frame   = (count_reg != '0) ? head_reg : '0;
        result.tail_frame   = (count_reg != '0) ? tail_reg : '0;
        result.frame_count  = count_reg;
        result.is_empty     = (count_reg == '0);
    end

endmodule

@@ hdl/plq_checker.sv @@
// plq_checker: port-level checks on the result channel of picture_list_deque
// bound to the top level below; depends on plq_pkg
module plq_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [plq_pkg::M_TDATA_W-1:0]   m_tdata
);
    import plq_pkg::*;

    // held result beat stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed while stalled");

    // empty flag agrees with the count
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[19] == (m_tdata[18:14] == 5'd0)))
        else $error("is_empty disagrees with frame_count");

    // count never exceeds the slot count
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[18:14] <= 5'd16))
        else $error("frame_count beyond slot count");

    // a miss reports frame zero, an empty list reports zero ends
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[0] || (m_tdata[4:1] == 4'd0)) &&
                      (!m_tdata[19] || (m_tdata[13:6] == 8'd0))))
        else $error("nonzero frame on miss or on empty list");

    // one beat in flight: the input closes right after a beat is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input still open after a beat was taken");

endmodule

bind picture_list_deque plq_checker u_plq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/picture_list_deque_tb.sv @@
// picture_list_deque_tb: self-checking bench for the picture list deque
// drives list operations on the input stream, predicts every result beat and checks each one
// depends on plq_pkg and picture_list_deque
module picture_list_deque_tb;
    import plq_pkg::*;

    // opcodes the block leaves undefined, sent to check that they change nothing
    localparam logic [OPCODE_W-1:0] OP_UNDEF_6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_UNDEF_7 = 3'd7;

    localparam int IDLE_PCT    = 29;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SHOW_MAX    = 10;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // list model: links, in-list bits, stored order counts, head, tail and length
    logic [LINK_W-1:0]  list_next [NUM_FRAMES];
    logic [LINK_W-1:0]  list_prev [NUM_FRAMES];
    logic [OC_W-1:0]    slot_poc [NUM_FRAMES];
    logic               slot_listed [NUM_FRAMES];
    logic [FRAME_W-1:0] list_head;
    logic [FRAME_W-1:0] list_tail;
    logic [COUNT_W-1:0] list_len;

    // result beats still owed by the block, oldest first
    plq_result_t expected_results [$];
    plq_result_t got_beat;
    plq_result_t want_beat;

    int mismatch_count  = 0;
    int cycle_count     = 0;
    int sink_hold_req   = 0;
    int sink_hold_left  = 0;
    bit src_quiet       = 1'b0;
    bit sink_quiet      = 1'b0;

    picture_list_deque i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // hard stop if the block hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // take a frame out of the model list and splice its neighbors together
    function automatic void unlink_frame(input logic [FRAME_W-1:0] f);
        logic [LINK_W-1:0] nxt;
        logic [LINK_W-1:0] prv;
        nxt = list_next[f];
        prv = list_prev[f];
        list_len = list_len - COUNT_W'(1);
        if (list_len != 0) begin
            if (list_head == f) list_head = nxt[FRAME_W-1:0];
            if (list_tail == f) list_tail = prv[FRAME_W-1:0];
            if (nxt != NIL_LINK) list_prev[nxt[FRAME_W-1:0]] = prv;
            if (prv != NIL_LINK) list_next[prv[FRAME_W-1:0]] = nxt;
        end else begin
            list_head = '0;
            list_tail = '0;
        end
        list_next[f]   = NIL_LINK;
        list_prev[f]   = NIL_LINK;
        slot_listed[f] = 1'b0;
    endfunction

    // apply one operation to the model list and return the beat it should produce
    function automatic plq_result_t predict_list_op(input logic [OPCODE_W-1:0] op,
                                                    input logic [FRAME_W-1:0] fid,
                                                    input logic [OC_W-1:0] poc);
        plq_result_t r;
        logic [LINK_W-1:0] walk;
        int steps;
        r = '0;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (slot_listed[fid]) begin
                    r.op_error = 1'b1;
                end else begin
                    slot_poc[fid] = poc;
                    if (op == OP_PUSH_FRONT) begin
                        list_next[fid] = (list_len != 0) ? LINK_W'(list_head) : NIL_LINK;
                        list_prev[fid] = NIL_LINK;
                        if (list_len != 0) list_prev[list_head] = LINK_W'(fid);
                        else list_tail = fid;
                        list_head = fid;
                    end else begin
                        list_prev[fid] = (list_len != 0) ? LINK_W'(list_tail) : NIL_LINK;
                        list_next[fid] = NIL_LINK;
                        if (list_len != 0) list_next[list_tail] = LINK_W'(fid);
                        else list_head = fid;
                        list_tail = fid;
                    end
                    slot_listed[fid] = 1'b1;
                    list_len = list_len + COUNT_W'(1);
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (list_len != 0) begin
                    r.hit          = 1'b1;
                    r.result_frame = (op == OP_POP_FRONT) ? list_head : list_tail;
                    unlink_frame(r.result_frame);
                end
            end
            OP_REMOVE: begin
                if (!slot_listed[fid]) r.op_error = 1'b1;
                else unlink_frame(fid);
            end
            OP_FIND: begin
                // first match in list order, all 32 bits compared
                walk  = (list_len != 0) ? LINK_W'(list_head) : NIL_LINK;
                steps = 0;
                while (walk != NIL_LINK && steps < NUM_FRAMES && !r.hit) begin
                    if (slot_poc[walk[FRAME_W-1:0]] == poc) begin
                        r.hit          = 1'b1;
                        r.result_frame = walk[FRAME_W-1:0];
                    end else begin
                        walk = list_next[walk[FRAME_W-1:0]];
                    end
                    steps++;
                end
            end
            default: ;
        endcase
        r.head_frame  = (list_len != 0) ? list_head : '0;
        r.tail_frame  = (list_len != 0) ? list_tail : '0;
        r.frame_count = list_len;
        r.is_empty    = (list_len == 0);
        return r;
    endfunction

    // a random frame that is (or is not) listed, if there is one
    function automatic logic [FRAME_W-1:0] pick_frame(input bit want_listed);
        logic [FRAME_W-1:0] start;
        logic [FRAME_W-1:0] cand;
        logic [FRAME_W-1:0] pick;
        bit found;
        start = FRAME_W'($urandom_range(NUM_FRAMES - 1));
        pick  = start;
        found = 1'b0;
        for (int i = 0; i < NUM_FRAMES; i++) begin
            cand = start + FRAME_W'(i);
            if (!found && slot_listed[cand] == want_listed) begin
                pick  = cand;
                found = 1'b1;
            end
        end
        return pick;
    endfunction

    // small pool of order counts so that duplicates and find hits are common
    function automatic logic [OC_W-1:0] pool_poc();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            4: return 32'h0000_0001;
            5: return 32'h0000_0002;
            6: return 32'h0000_0010;
            default: return 32'hffff_fff0;
        endcase
    endfunction

    // offer one beat, with random idle cycles first unless the source is quiet, and predict it once accepted
    task automatic send_list_op(input logic [OPCODE_W-1:0] op, input logic [FRAME_W-1:0] fid,
                                input logic [OC_W-1:0] poc);
        while (!src_quiet && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({poc, fid, op});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(predict_list_op(op, fid, poc));
    endtask

    // weighted mix: mostly meaningful operations on the current list, some errors and noise
    task automatic send_random_list_op();
        int roll;
        int push_w;
        logic [OPCODE_W-1:0] op;
        logic [FRAME_W-1:0]  fid;
        logic [OC_W-1:0]     poc;
        roll   = $urandom_range(99);
        push_w = (list_len >= 12) ? 20 : 40;
        fid    = FRAME_W'($urandom());
        poc    = $urandom();
        if (roll < push_w) begin
            op  = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            fid = pick_frame($urandom_range(9) == 0);
            if ($urandom_range(1)) poc = pool_poc();
        end else if (roll < push_w + 20) begin
            op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
        end else if (roll < push_w + 33) begin
            op  = OP_REMOVE;
            fid = pick_frame($urandom_range(4) != 0);
        end else if (roll < 96) begin
            op = OP_FIND;
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: poc = slot_poc[pick_frame(1'b1)];
                6, 7: poc = pool_poc();
                default: ;
            endcase
        end else begin
            op = $urandom_range(1) ? OP_UNDEF_7 : OP_UNDEF_6;
        end
        send_list_op(op, fid, poc);
    endtask

    // stop offering until every owed beat has come back
    task automatic wait_list_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_results.size() != 0);
    endtask

    // empty-list cases, errors, undefined opcodes, finds at head/middle/tail, extremes
    task automatic test_directed();
        send_list_op(OP_POP_FRONT, 4'd0, 32'h0);
        send_list_op(OP_POP_BACK, 4'd0, 32'h0);
        send_list_op(OP_REMOVE, 4'd3, 32'h0);
        send_list_op(OP_FIND, 4'd0, 32'h0);
        send_list_op(OP_UNDEF_6, 4'd15, 32'hffff_ffff);
        send_list_op(OP_UNDEF_7, 4'd0, 32'h8000_0000);
        send_list_op(OP_PUSH_BACK, 4'd0, 32'h8000_0000);
        send_list_op(OP_PUSH_FRONT, 4'd15, 32'h7fff_ffff);
        send_list_op(OP_PUSH_BACK, 4'd7, 32'hffff_ffff);
        send_list_op(OP_PUSH_FRONT, 4'd15, 32'h1234_5678);   // already listed
        send_list_op(OP_FIND, 4'd0, 32'h7fff_ffff);
        send_list_op(OP_FIND, 4'd0, 32'hffff_ffff);
        send_list_op(OP_FIND, 4'd0, 32'h8000_0000);
        send_list_op(OP_FIND, 4'd0, 32'h8000_0001);          // near miss in the low bit
        send_list_op(OP_REMOVE, 4'd0, 32'h0);                // middle node
        send_list_op(OP_REMOVE, 4'd0, 32'h0);                // now unlisted
        send_list_op(OP_POP_BACK, 4'd0, 32'h0);
        send_list_op(OP_POP_FRONT, 4'd0, 32'h0);
        wait_list_drained();
    endtask

    // fill all sixteen slots, walk the whole list, then empty it again
    task automatic test_full_list();
        logic [FRAME_W-1:0] order [NUM_FRAMES];
        logic [FRAME_W-1:0] tmp;
        int j;
        for (int i = 0; i < NUM_FRAMES; i++) order[i] = FRAME_W'(i);
        for (int i = NUM_FRAMES - 1; i > 0; i--) begin
            j        = $urandom_range(i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        // low nibble of the order count is the push index, so every count is unique
        for (int i = 0; i < NUM_FRAMES; i++)
            send_list_op($urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT, order[i],
                         {28'($urandom()), 4'(i)});
        send_list_op(OP_PUSH_BACK, FRAME_W'($urandom()), $urandom());
        send_list_op(OP_FIND, 4'd0, slot_poc[list_tail]);
        send_list_op(OP_FIND, 4'd0, slot_poc[list_tail] ^ 32'h8000_0000);
        for (int i = 0; i < 4; i++) send_list_op(OP_REMOVE, pick_frame(1'b1), $urandom());
        while (list_len != 0)
            send_list_op($urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT, 4'd0, $urandom());
    endtask

    // bulk random traffic, the first stretch with no idle cycles on either side
    task automatic test_random_ops(input int n_items);
        src_quiet  = 1'b1;
        sink_quiet = 1'b1;
        for (int i = 0; i < n_items; i++) begin
            if (i == 150) begin
                src_quiet  = 1'b0;
                sink_quiet = 1'b0;
            end
            send_random_list_op();
        end
    endtask

    // receiver holds off for a long stretch while beats keep coming
    task automatic test_backpressure();
        sink_hold_req = 400;
        for (int i = 0; i < 30; i++) send_random_list_op();
        wait_list_drained();
    endtask

    // short bursts, each followed by a full drain
    task automatic test_drain_pause();
        for (int i = 0; i < 10; i++) begin
            for (int k = 0; k < 5; k++) send_random_list_op();
            wait_list_drained();
        end
    endtask

    // receiver: random ready, long hold on request, and the beat check
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_beat = plq_result_t'(m_tdata[M_FIELDS_W-1:0]);
                if (expected_results.size() == 0) begin
                    if (mismatch_count < SHOW_MAX)
                        $display("unexpected result beat: %h", m_tdata);
                    mismatch_count++;
                end else begin
                    want_beat = expected_results.pop_front();
                    if (got_beat.hit != want_beat.hit ||
                        got_beat.result_frame != want_beat.result_frame ||
                        got_beat.op_error != want_beat.op_error ||
                        got_beat.head_frame != want_beat.head_frame ||
                        got_beat.tail_frame != want_beat.tail_frame ||
                        got_beat.frame_count != want_beat.frame_count ||
                        got_beat.is_empty != want_beat.is_empty) begin
                        if (mismatch_count < SHOW_MAX) begin
                            $display("exp hit %0d frm %0d err %0d hd %0d tl %0d n %0d e %0d",
                                     want_beat.hit, want_beat.result_frame, want_beat.op_error,
                                     want_beat.head_frame, want_beat.tail_frame,
                                     want_beat.frame_count, want_beat.is_empty);
                            $display("got hit %0d frm %0d err %0d hd %0d tl %0d n %0d e %0d",
                                     got_beat.hit, got_beat.result_frame, got_beat.op_error,
                                     got_beat.head_frame, got_beat.tail_frame,
                                     got_beat.frame_count, got_beat.is_empty);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (sink_hold_req != 0) begin
                sink_hold_left = sink_hold_req;
                sink_hold_req  = 0;
            end
            if (sink_hold_left != 0) begin
                m_tready <= 1'b0;
                sink_hold_left--;
            end else begin
                m_tready <= sink_quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        for (int i = 0; i < NUM_FRAMES; i++) begin
            list_next[i]   = NIL_LINK;
            list_prev[i]   = NIL_LINK;
            slot_poc[i]    = '0;
            slot_listed[i] = 1'b0;
        end
        list_head = '0;
        list_tail = '0;
        list_len  = '0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_full_list();
        test_random_ops(650);
        test_backpressure();
        test_drain_pause();

        wait_list_drained();
        // longest operation is a full find walk; leave room for any stray beat
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
